[hdl/plcl_pkg.sv]
// Shared types and constants for the particle cell-list builder.
package plcl_pkg;

    localparam int ID_W         = 16;
    localparam int POS_W        = 24;
    localparam int CELLS_W      = 13;
    localparam int CNT_W        = 17;
    localparam int INDEX_OUT_W  = 12;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CELL_SHIFT   = 10;
    localparam int COUNT_FIELD_MAX = 131071;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Z = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_START = 2'd3;

    typedef enum logic
    {
        OP_CLEAR  = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // Classified command passed from front to back.
    typedef struct packed
    {
        op_t             op;
        logic            cfg_bad;
        logic [ID_W-1:0] particle_id;
    } cmd_t;

    // One cell record in the cell RAM.
    typedef struct packed
    {
        logic             head_valid;
        logic [ID_W-1:0]  head_id;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

[hdl/plcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plcl_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/plcl_front.sv]
// Front end: accepts items, computes cell index and config check in three stages.
module plcl_front #(
    parameter int MAX_CELLS = 4096,
    parameter int IDX_W     = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              hold,
    input  logic                              opcode,
    input  logic [plcl_pkg::ID_W-1:0]         particle_id,
    input  logic [plcl_pkg::POS_W-1:0]        pos_x,
    input  logic [plcl_pkg::POS_W-1:0]        pos_y,
    input  logic [plcl_pkg::POS_W-1:0]        pos_z,
    input  logic [plcl_pkg::CELLS_W-1:0]      cells_x,
    input  logic [plcl_pkg::CELLS_W-1:0]      cells_y,
    input  logic [plcl_pkg::CELLS_W-1:0]      cells_z,
    input  logic [plcl_pkg::POS_W-1:0]        z_start,
    output logic                              push_valid,
    input  logic                              push_full,
    output plcl_pkg::cmd_t                    push_cmd,
    output logic [IDX_W-1:0]                  push_idx
);

    localparam int RAW_W  = plcl_pkg::POS_W - plcl_pkg::CELL_SHIFT;
    localparam int CW     = plcl_pkg::CELLS_W;
    localparam int P1_W   = 2 * CW;
    localparam int SUM_W  = P1_W + 1;
    localparam int P2_W   = SUM_W + CW;
    localparam int TOT_W  = 3 * CW;

    function automatic logic [CW-1:0] clamp_axis(
        input logic [plcl_pkg::POS_W-1:0] span,
        input logic [CW-1:0]              count
    );
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] top;
        raw = span[plcl_pkg::POS_W-1:plcl_pkg::CELL_SHIFT];
        top = RAW_W'(count) - RAW_W'(1);
        return (raw > top) ? top[CW-1:0] : raw[CW-1:0];
    endfunction

    logic                    en;
    logic                    accept;
    logic [plcl_pkg::POS_W-1:0] dz;
    logic [SUM_W-1:0]        s2_sum;
    logic [P2_W-1:0]         s2_prod;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s3_valid_reg, s3_valid_next;
    plcl_pkg::cmd_t          s1_cmd_reg, s2_cmd_reg, s3_cmd_reg;
    logic [CW-1:0]           s1_ix_reg, s1_iy_reg, s1_iz_reg;
    logic [CW-1:0]           s2_ix_reg, s2_iy_reg, s3_ix_reg;
    logic [P1_W-1:0]         s1_cxy_reg, s2_t1_reg;
    logic [TOT_W-1:0]        s2_total_reg;
    logic                    s1_zero_reg, s2_zero_reg;
    logic [IDX_W-1:0]        s3_part_reg;

    assign en       = !s3_valid_reg || !push_full;
    assign in_stall = !en || hold;
    assign accept   = in_valid && !in_stall;

    assign dz = (pos_z >= z_start) ? (pos_z - z_start) : '0;

    assign s2_sum  = SUM_W'(s2_iy_reg) + SUM_W'(s2_t1_reg);
    assign s2_prod = P2_W'(cells_x) * P2_W'(s2_sum);

    assign s1_valid_next = en ? accept : s1_valid_reg;
    assign s2_valid_next = en ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = en ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: axis cells, x*y extent
            s1_cmd_reg.op          <= plcl_pkg::op_t'(opcode);
            s1_cmd_reg.cfg_bad     <= 1'b0;
            s1_cmd_reg.particle_id <= particle_id;
            s1_ix_reg   <= clamp_axis(pos_x, cells_x);
            s1_iy_reg   <= clamp_axis(pos_y, cells_y);
            s1_iz_reg   <= clamp_axis(dz, cells_z);
            s1_cxy_reg  <= P1_W'(cells_x) * P1_W'(cells_y);
            s1_zero_reg <= (cells_x == '0) || (cells_y == '0) || (cells_z == '0);

            // stage 2: cells_y * z, total cell count
            s2_cmd_reg   <= s1_cmd_reg;
            s2_ix_reg    <= s1_ix_reg;
            s2_iy_reg    <= s1_iy_reg;
            s2_t1_reg    <= P1_W'(cells_y) * P1_W'(s1_iz_reg);
            s2_total_reg <= TOT_W'(s1_cxy_reg) * TOT_W'(cells_z);
            s2_zero_reg  <= s1_zero_reg;

            // stage 3: cells_x * (y + cells_y * z), range check
            s3_cmd_reg.op          <= s2_cmd_reg.op;
            s3_cmd_reg.particle_id <= s2_cmd_reg.particle_id;
            s3_cmd_reg.cfg_bad     <= s2_zero_reg || (s2_total_reg > TOT_W'(MAX_CELLS));
            s3_ix_reg   <= s2_ix_reg;
            s3_part_reg <= IDX_W'(s2_prod);
        end
    end

    assign push_valid = s3_valid_reg;
    assign push_cmd   = s3_cmd_reg;
    assign push_idx   = IDX_W'(s3_ix_reg) + s3_part_reg;

endmodule

[hdl/plcl_queue.sv]
// Small register FIFO between front and back.
module plcl_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/plcl_back.sv]
// Back end: cell RAM sweep, read-modify-write of head and count, result register.
module plcl_back #(
    parameter int MAX_CELLS     = 4096,
    parameter int MAX_PARTICLES = 65536,
    parameter int IDX_W         = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pop_valid,
    output logic                                 pop,
    input  plcl_pkg::cmd_t                       pop_cmd,
    input  logic [IDX_W-1:0]                     pop_idx,
    output logic                                 init_busy,
    output logic                                 ram_we,
    output logic [IDX_W-1:0]                     ram_waddr,
    output plcl_pkg::entry_t                     ram_wdata,
    output logic [IDX_W-1:0]                     ram_raddr,
    input  plcl_pkg::entry_t                     ram_rdata,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [plcl_pkg::INDEX_OUT_W-1:0]     cell_index,
    output logic [plcl_pkg::ID_W-1:0]            next_particle,
    output logic                                 next_valid,
    output logic [plcl_pkg::CNT_W-1:0]           cell_count,
    output logic                                 config_error
);

    localparam int CNT_W = plcl_pkg::CNT_W;
    localparam logic [CNT_W-1:0] COUNT_LIM = CNT_W'((MAX_PARTICLES > plcl_pkg::COUNT_FIELD_MAX)
                                                    ? plcl_pkg::COUNT_FIELD_MAX
                                                    : MAX_PARTICLES);
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_CELLS - 1);

    typedef enum logic [2:0]
    {
        ST_SWEEP  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        sweep_reg, sweep_next;
    logic                    init_reg, init_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [plcl_pkg::ID_W-1:0] pid_reg, pid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [plcl_pkg::INDEX_OUT_W-1:0] out_index_reg, out_index_next;
    logic [plcl_pkg::ID_W-1:0] out_next_reg, out_next_next;
    logic                    out_nvalid_reg, out_nvalid_next;
    logic [CNT_W-1:0]        out_count_reg, out_count_next;
    logic                    out_err_reg, out_err_next;
    logic                    out_take;
    logic                    out_free;
    logic [CNT_W-1:0]        new_count;

    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;
    assign new_count = (ram_rdata.count < COUNT_LIM) ? ram_rdata.count + CNT_W'(1)
                                                     : ram_rdata.count;
    assign ram_raddr = pop_idx;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        init_next       = init_reg;
        idx_next        = idx_reg;
        pid_next        = pid_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        out_index_next  = out_index_reg;
        out_next_next   = out_next_reg;
        out_nvalid_next = out_nvalid_reg;
        out_count_next  = out_count_reg;
        out_err_next    = out_err_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = sweep_reg;
        ram_wdata       = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we = 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop             = 1'b1;
                    out_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_next_next   = '0;
                    out_nvalid_next = 1'b0;
                    out_count_next  = '0;
                    out_err_next    = 1'b0;
                    unique case (pop_cmd.op)
                        plcl_pkg::OP_CLEAR:
                        begin
                            state_next = ST_SWEEP;
                            sweep_next = '0;
                        end
                        plcl_pkg::OP_INSERT:
                        begin
                            if (pop_cmd.cfg_bad)
                            begin
                                out_err_next = 1'b1;
                            end
                            else
                            begin
                                // result comes after the RAM read
                                out_valid_next = out_take ? 1'b0 : out_valid_reg;
                                idx_next       = pop_idx;
                                pid_next       = pop_cmd.particle_id;
                                state_next     = ST_MODIFY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                ram_we               = 1'b1;
                ram_waddr            = idx_reg;
                ram_wdata.head_valid = 1'b1;
                ram_wdata.head_id    = pid_reg;
                ram_wdata.count      = new_count;
                out_valid_next       = 1'b1;
                out_index_next       = plcl_pkg::INDEX_OUT_W'(idx_reg);
                out_next_next        = ram_rdata.head_id;
                out_nvalid_next      = ram_rdata.head_valid;
                out_count_next       = new_count;
                out_err_next         = 1'b0;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pid_reg        <= pid_next;
        out_index_reg  <= out_index_next;
        out_next_reg   <= out_next_next;
        out_nvalid_reg <= out_nvalid_next;
        out_count_reg  <= out_count_next;
        out_err_reg    <= out_err_next;
    end

    assign init_busy     = init_reg;
    assign out_valid     = out_valid_reg;
    assign cell_index    = out_index_reg;
    assign next_particle = out_next_reg;
    assign next_valid    = out_nvalid_reg;
    assign cell_count    = out_count_reg;
    assign config_error  = out_err_reg;

endmodule

[hdl/particle_cell_list_builder.sv]
// Top level of the particle cell-list builder: config registers and block wiring.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | opcode, particle_id, pos_x, pos_y, pos_z
//  result   | out_valid / out_stall| cell_index, next_particle, next_valid,
//           |                      | cell_count, config_error
//  config   | cfg_write            | cfg_index, cfg_data
//
//  Insert: the back takes a new item only after the read-modify-write of the
//  cell RAM (one read port, one write port) for the last insert; an insert's
//  result is registered after the RAM read, a clear's or a refused insert's
//  when the back takes the item.
//  Clear: the back takes the item, then clears one cell RAM entry per cycle.
//  After reset a clearing pass over all MAX_CELLS entries runs with in_stall high.
//  A 2-entry queue between front and back lets the front accept items while
//  the back is busy or its result waits on out_stall.
module particle_cell_list_builder #(
    parameter int MAX_CELLS     = 4096,
    parameter int MAX_PARTICLES = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [plcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [plcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [plcl_pkg::ID_W-1:0]            particle_id,
    input  logic [plcl_pkg::POS_W-1:0]           pos_x,
    input  logic [plcl_pkg::POS_W-1:0]           pos_y,
    input  logic [plcl_pkg::POS_W-1:0]           pos_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [plcl_pkg::INDEX_OUT_W-1:0]     cell_index,
    output logic [plcl_pkg::ID_W-1:0]            next_particle,
    output logic                                 next_valid,
    output logic [plcl_pkg::CNT_W-1:0]           cell_count,
    output logic                                 config_error
);

    localparam int IDX_W   = $clog2(MAX_CELLS);
    localparam int CMD_W   = $bits(plcl_pkg::cmd_t);
    localparam int QW      = CMD_W + IDX_W;
    localparam int ENTRY_W = $bits(plcl_pkg::entry_t);
    localparam int CW      = plcl_pkg::CELLS_W;

    logic [CW-1:0]                 cells_x_reg, cells_y_reg, cells_z_reg;
    logic [plcl_pkg::POS_W-1:0]    z_start_reg;

    logic                          init_busy;
    logic                          push_valid, push_full;
    plcl_pkg::cmd_t                push_cmd;
    logic [IDX_W-1:0]              push_idx;
    logic                          pop_valid, pop;
    logic [QW-1:0]                 pop_data;
    plcl_pkg::cmd_t                pop_cmd;
    logic [IDX_W-1:0]              pop_idx;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr, ram_raddr;
    plcl_pkg::entry_t              ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0]            ram_rdata_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CW'(1);
            cells_y_reg <= CW'(1);
            cells_z_reg <= CW'(1);
            z_start_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                plcl_pkg::REG_CELLS_X: cells_x_reg <= cfg_data[CW-1:0];
                plcl_pkg::REG_CELLS_Y: cells_y_reg <= cfg_data[CW-1:0];
                plcl_pkg::REG_CELLS_Z: cells_z_reg <= cfg_data[CW-1:0];
                plcl_pkg::REG_Z_START: z_start_reg <= cfg_data[plcl_pkg::POS_W-1:0];
                default:               z_start_reg <= z_start_reg;
            endcase
        end
    end

    plcl_front #(
        .MAX_CELLS (MAX_CELLS),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hold        (init_busy),
        .opcode      (opcode),
        .particle_id (particle_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .cells_x     (cells_x_reg),
        .cells_y     (cells_y_reg),
        .cells_z     (cells_z_reg),
        .z_start     (z_start_reg),
        .push_valid  (push_valid),
        .push_full   (push_full),
        .push_cmd    (push_cmd),
        .push_idx    (push_idx)
    );

    plcl_queue #(
        .WIDTH (QW),
        .DEPTH (plcl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_cmd, push_idx}),
        .full      (push_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    assign pop_cmd = plcl_pkg::cmd_t'(pop_data[QW-1:IDX_W]);
    assign pop_idx = pop_data[IDX_W-1:0];

    plcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = plcl_pkg::entry_t'(ram_rdata_raw);

    plcl_back #(
        .MAX_CELLS     (MAX_CELLS),
        .MAX_PARTICLES (MAX_PARTICLES),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .pop_idx       (pop_idx),
        .init_busy     (init_busy),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_index    (cell_index),
        .next_particle (next_particle),
        .next_valid    (next_valid),
        .cell_count    (cell_count),
        .config_error  (config_error)
    );

endmodule

[hdl/plcl_checker.sv]
// Port-level assertions for the particle cell-list builder, bound to the top level.
module plcl_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [plcl_pkg::INDEX_OUT_W-1:0]     cell_index,
    input logic [plcl_pkg::ID_W-1:0]            next_particle,
    input logic                                 next_valid,
    input logic [plcl_pkg::CNT_W-1:0]           cell_count,
    input logic                                 config_error
);

    // refused insert carries nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |->
            (cell_index == '0) && (next_particle == '0) && !next_valid && (cell_count == '0))
        else $error("config error item carries nonzero fields");

    // empty cell before the insert: count is at most one afterwards
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !config_error && !next_valid |-> (cell_count <= 17'd1))
        else $error("end-of-list item with count above one");

    // linked cell already held a particle: count at least two
    a_linked_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !config_error && next_valid |-> (cell_count >= 17'd2))
        else $error("linked item with count below two");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_count) && $stable(cell_index))
        else $error("stalled result changed");

endmodule

bind particle_cell_list_builder plcl_checker u_plcl_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the particle cell-list builder: directed, one-cell and random runs.
module tb_top;
    import plcl_pkg::*;

    localparam int MAX_CELLS_TB     = 4096;
    localparam int MAX_PARTICLES_TB = 65536;
    localparam int COUNT_LIMIT      = (MAX_PARTICLES_TB < COUNT_FIELD_MAX) ?
                                      MAX_PARTICLES_TB : COUNT_FIELD_MAX;
    localparam int SETTLE_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int SAT_ITEMS        = 300;
    localparam int RANDOM_PHASES    = 14;
    localparam int PHASE_ITEMS      = 125;
    localparam int BAD_PHASE_ITEMS  = 12;
    localparam int REPORT_CAP       = 40;

    typedef struct packed
    {
        logic [INDEX_OUT_W-1:0] cell_index;
        logic [ID_W-1:0]        next_particle;
        logic                   next_valid;
        logic [CNT_W-1:0]       cell_count;
        logic                   config_error;
    } cell_result_t;

    typedef enum logic [1:0]
    {
        ROW_GRID,
        ROW_ITEM,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t          kind;
        op_t                op;
        logic [ID_W-1:0]    pid;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   pz;
        logic [CELLS_W-1:0] cx;
        logic [CELLS_W-1:0] cy;
        logic [CELLS_W-1:0] cz;
        logic [POS_W-1:0]   zs;
        cell_result_t       want;
    } dir_row_t;

    localparam cell_result_t NO_RESULT  = '0;
    localparam cell_result_t BAD_CONFIG = '{12'd0, 16'd0, 1'b0, 17'd0, 1'b1};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   opcode = 1'b0;
    logic [ID_W-1:0]        particle_id = '0;
    logic [POS_W-1:0]       pos_x = '0;
    logic [POS_W-1:0]       pos_y = '0;
    logic [POS_W-1:0]       pos_z = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [INDEX_OUT_W-1:0] cell_index;
    logic [ID_W-1:0]        next_particle;
    logic                   next_valid;
    logic [CNT_W-1:0]       cell_count;
    logic                   config_error;

    logic                   item_typed = 1'b0;
    cell_result_t           typed_result = '0;

    logic [CELLS_W-1:0]     grid_x = 13'd1;
    logic [CELLS_W-1:0]     grid_y = 13'd1;
    logic [CELLS_W-1:0]     grid_z = 13'd1;
    logic [POS_W-1:0]       slab_base = '0;
    logic [ID_W:0]          list_head [MAX_CELLS_TB];
    logic [CNT_W-1:0]       list_len [MAX_CELLS_TB];

    cell_result_t           expected_bins [$];
    dir_row_t               directed_rows [$];
    int                     items_sent = 0;
    int                     results_seen = 0;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    int                     stall_left = 0;
    logic                   idle_on = 1'b1;

    particle_cell_list_builder DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_error(input string what);
        if (error_count < REPORT_CAP)
            $display("ERROR: %s", what);
        error_count++;
    endtask

    function automatic void wipe_lists();
        for (int c = 0; c < MAX_CELLS_TB; c++)
        begin
            list_head[c] = '0;
            list_len[c]  = '0;
        end
    endfunction

    function automatic int unsigned axis_bin(input logic [POS_W-1:0] span,
                                             input logic [CELLS_W-1:0] n);
        int unsigned c;
        c = 32'(span) >> CELL_SHIFT;
        if (c > 32'(n) - 1)
            c = 32'(n) - 1;
        return c;
    endfunction

    function automatic cell_result_t bin_particle(input op_t op, input logic [ID_W-1:0] pid,
                                                  input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y,
                                                  input logic [POS_W-1:0] z);
        cell_result_t     r;
        logic [63:0]      cells;
        logic [POS_W-1:0] dz;
        int unsigned      ix;
        int unsigned      iy;
        int unsigned      iz;
        int unsigned      idx;
        r = NO_RESULT;
        if (op == OP_CLEAR)
        begin
            wipe_lists();
            return r;
        end
        cells = 64'(grid_x) * 64'(grid_y) * 64'(grid_z);
        if (grid_x == 0 || grid_y == 0 || grid_z == 0 || cells > 64'(MAX_CELLS_TB))
            return BAD_CONFIG;
        dz  = (z >= slab_base) ? z - slab_base : '0;
        ix  = axis_bin(x, grid_x);
        iy  = axis_bin(y, grid_y);
        iz  = axis_bin(dz, grid_z);
        idx = ix + 32'(grid_x) * (iy + 32'(grid_y) * iz);
        r.cell_index    = idx[INDEX_OUT_W-1:0];
        r.next_particle = list_head[idx][ID_W-1:0];
        r.next_valid    = list_head[idx][ID_W];
        if (32'(list_len[idx]) < COUNT_LIMIT)
            list_len[idx] = list_len[idx] + 1'b1;
        r.cell_count    = list_len[idx];
        list_head[idx]  = {1'b1, pid};
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_coord(input logic [CELLS_W-1:0] n,
                                                    input logic [POS_W-1:0] base);
        int unsigned roll;
        int unsigned v;
        roll = $urandom_range(0, 9);
        if (roll == 0 || n == 0)
            return 24'($urandom());
        if (roll == 1)
            return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        v = 32'(base) + (($urandom_range(0, 32'(n) - 1) << CELL_SHIFT) |
                         $urandom_range(0, 1023));
        return (v > 32'hFFFFFF) ? 24'hFFFFFF : v[POS_W-1:0];
    endfunction

    function automatic dir_row_t grid_row(input logic [CELLS_W-1:0] cx,
                                          input logic [CELLS_W-1:0] cy,
                                          input logic [CELLS_W-1:0] cz,
                                          input logic [POS_W-1:0] zs);
        dir_row_t r;
        r = '0;
        r.kind = ROW_GRID;
        r.cx = cx;
        r.cy = cy;
        r.cz = cz;
        r.zs = zs;
        return r;
    endfunction

    function automatic dir_row_t item_row(input op_t op, input logic [ID_W-1:0] pid,
                                          input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y,
                                          input logic [POS_W-1:0] z);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.pid = pid;
        r.px = x;
        r.py = y;
        r.pz = z;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input op_t op, input logic [ID_W-1:0] pid,
                                           input logic [POS_W-1:0] x,
                                           input logic [POS_W-1:0] y,
                                           input logic [POS_W-1:0] z,
                                           input cell_result_t want);
        dir_row_t r;
        r = item_row(op, pid, x, y, z);
        r.kind = ROW_TYPED;
        r.want = want;
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [ID_W-1:0] pid,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z, input logic typed,
                             input cell_result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        particle_id  <= pid;
        pos_x        <= x;
        pos_y        <= y;
        pos_z        <= z;
        item_typed   <= typed;
        typed_result <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input logic [CELLS_W-1:0] cx, input logic [CELLS_W-1:0] cy,
                            input logic [CELLS_W-1:0] cz, input logic [POS_W-1:0] zs);
        wait_drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_CELLS_X;
        cfg_data  <= 24'(cx);
        @(posedge clk);
        cfg_index <= REG_CELLS_Y;
        cfg_data  <= 24'(cy);
        @(posedge clk);
        cfg_index <= REG_CELLS_Z;
        cfg_data  <= 24'(cz);
        @(posedge clk);
        cfg_index <= REG_Z_START;
        cfg_data  <= zs;
        @(posedge clk);
        cfg_write <= 1'b0;
        grid_x    = cx;
        grid_y    = cy;
        grid_z    = cz;
        slab_base = zs;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 6);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cell_result_t want;
        cell_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = bin_particle(op_t'(opcode), particle_id, pos_x, pos_y, pos_z);
                if (item_typed)
                    want = typed_result;
                expected_bins.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got = '{cell_index, next_particle, next_valid, cell_count, config_error};
                if (expected_bins.size() == 0)
                    report_error("result arrived with no item pending");
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.cell_index !== want.cell_index)
                        report_error($sformatf("cell_index got %0d expected %0d",
                                               got.cell_index, want.cell_index));
                    if (got.next_particle !== want.next_particle)
                        report_error($sformatf("next_particle got %0d expected %0d",
                                               got.next_particle, want.next_particle));
                    if (got.next_valid !== want.next_valid)
                        report_error($sformatf("next_valid got %0b expected %0b",
                                               got.next_valid, want.next_valid));
                    if (got.cell_count !== want.cell_count)
                        report_error($sformatf("cell_count got %0d expected %0d",
                                               got.cell_count, want.cell_count));
                    if (got.config_error !== want.config_error)
                        report_error($sformatf("config_error got %0b expected %0b",
                                               got.config_error, want.config_error));
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t         row;
        logic [CELLS_W-1:0] cx;
        logic [CELLS_W-1:0] cy;
        logic [CELLS_W-1:0] cz;
        logic [POS_W-1:0]   zs;
        int               sel;
        int               n_items;
        op_t              op;

        wipe_lists();

        // reset values: 1x1x1 grid, slab at zero
        directed_rows.push_back(typed_row(OP_INSERT, 16'h0000, 24'h000000, 24'h000000,
                                          24'h000000, '{12'd0, 16'd0, 1'b0, 17'd1, 1'b0}));
        directed_rows.push_back(typed_row(OP_INSERT, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                          24'hFFFFFF, '{12'd0, 16'd0, 1'b1, 17'd2, 1'b0}));
        directed_rows.push_back(typed_row(OP_CLEAR, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                          24'hFFFFFF, NO_RESULT));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h1234, 24'h000000, 24'h000000,
                                          24'h000000, '{12'd0, 16'd0, 1'b0, 17'd1, 1'b0}));
        directed_rows.push_back(grid_row(13'd4096, 13'd1, 13'd1, 24'h000000));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h0005, 24'hFFFFFF, 24'h000000,
                                          24'h000000, '{12'd4095, 16'd0, 1'b0, 17'd1, 1'b0}));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h0006, 24'h3FFC00, 24'h000000,
                                          24'h000000, '{12'd4095, 16'd5, 1'b1, 17'd2, 1'b0}));
        directed_rows.push_back(item_row(OP_INSERT, 16'h0007, 24'h0003FF, 24'h000000,
                                         24'h000000));
        directed_rows.push_back(grid_row(13'd1, 13'd4096, 13'd1, 24'h000000));
        directed_rows.push_back(item_row(OP_INSERT, 16'h0008, 24'h000000, 24'hFFFFFF,
                                         24'h000000));
        directed_rows.push_back(grid_row(13'd1, 13'd1, 13'd4096, 24'hFFFFFF));
        directed_rows.push_back(item_row(OP_INSERT, 16'h0009, 24'h000000, 24'h000000,
                                         24'h000000));
        directed_rows.push_back(item_row(OP_INSERT, 16'h000A, 24'h000000, 24'h000000,
                                         24'hFFFFFF));
        directed_rows.push_back(grid_row(13'd1, 13'd1, 13'd4096, 24'h000400));
        directed_rows.push_back(item_row(OP_INSERT, 16'h000B, 24'h000000, 24'h000000,
                                         24'h0003FF));
        directed_rows.push_back(item_row(OP_INSERT, 16'h000C, 24'h000000, 24'h000000,
                                         24'hFFFFFF));
        directed_rows.push_back(grid_row(13'd16, 13'd16, 13'd16, 24'h555555));
        directed_rows.push_back(item_row(OP_INSERT, 16'hABCD, 24'h2AAAAA, 24'h155555,
                                         24'h5A5A5A));
        directed_rows.push_back(grid_row(13'd0, 13'd16, 13'd16, 24'h000000));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h1111, 24'h000000, 24'h000000,
                                          24'h000000, BAD_CONFIG));
        directed_rows.push_back(grid_row(13'd17, 13'd16, 13'd16, 24'h000000));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h2222, 24'h001000, 24'h000000,
                                          24'h000000, BAD_CONFIG));
        directed_rows.push_back(typed_row(OP_CLEAR, 16'h0000, 24'h000000, 24'h000000,
                                          24'h000000, NO_RESULT));
        directed_rows.push_back(grid_row(13'd8191, 13'd8191, 13'd8191, 24'h000000));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h3333, 24'hFFFFFF, 24'hFFFFFF,
                                          24'hFFFFFF, BAD_CONFIG));
        directed_rows.push_back(grid_row(13'd16, 13'd16, 13'd16, 24'h000000));
        directed_rows.push_back(typed_row(OP_INSERT, 16'h0F0F, 24'h000000, 24'h000000,
                                          24'h000000, '{12'd0, 16'd0, 1'b0, 17'd1, 1'b0}));
        directed_rows.push_back(item_row(OP_INSERT, 16'hF0F0, 24'h0003FF, 24'h0003FF,
                                         24'h0003FF));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_GRID:  set_grid(row.cx, row.cy, row.cz, row.zs);
                ROW_TYPED: send_item(row.op, row.pid, row.px, row.py, row.pz, 1'b1, row.want);
                default:   send_item(row.op, row.pid, row.px, row.py, row.pz, 1'b0, NO_RESULT);
            endcase
        end

        // one cell takes a long run of back-to-back inserts
        idle_on = 1'b0;
        set_grid(13'd1, 13'd1, 13'd1, 24'($urandom()));
        send_item(OP_CLEAR, 16'($urandom()), 24'($urandom()), 24'($urandom()),
                  24'($urandom()), 1'b0, NO_RESULT);
        for (int k = 0; k < SAT_ITEMS; k++)
            send_item(OP_INSERT, 16'($urandom()), 24'($urandom()), 24'($urandom()),
                      24'($urandom()), 1'b0, NO_RESULT);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sel = $urandom_range(0, 9);
            cx = 13'd1;
            cy = 13'd1;
            cz = 13'd1;
            case (sel)
                0:
                begin
                    cx = CELLS_W'($urandom_range(1, 4));
                    cy = CELLS_W'($urandom_range(1, 4));
                    cz = CELLS_W'($urandom_range(1, 4));
                end
                1:
                begin
                    cx = CELLS_W'($urandom_range(1, 8));
                    cy = CELLS_W'($urandom_range(1, 8));
                    cz = CELLS_W'($urandom_range(1, 8));
                end
                2:
                begin
                    cx = CELLS_W'($urandom_range(1, 64));
                    cy = CELLS_W'($urandom_range(1, 64));
                end
                3:
                begin
                    case ($urandom_range(0, 2))
                        0:       cx = 13'd4096;
                        1:       cy = 13'd4096;
                        default: cz = 13'd4096;
                    endcase
                end
                4:
                begin
                    cx = 13'd16;
                    cy = 13'd16;
                    cz = 13'd16;
                end
                5:
                begin
                    cx = CELLS_W'($urandom_range(1, 16));
                    cy = CELLS_W'($urandom_range(1, 16));
                    cz = CELLS_W'($urandom_range(1, 16));
                    case ($urandom_range(0, 2))
                        0:       cx = 13'd0;
                        1:       cy = 13'd0;
                        default: cz = 13'd0;
                    endcase
                end
                6:
                begin
                    cx = CELLS_W'($urandom_range(4097, 8191));
                    cy = CELLS_W'($urandom_range(1, 8191));
                    cz = CELLS_W'($urandom_range(1, 8191));
                end
                default:
                begin
                    cx = CELLS_W'($urandom_range(1, 16));
                    cy = CELLS_W'($urandom_range(1, 16));
                    cz = CELLS_W'($urandom_range(1, 16));
                end
            endcase
            case ($urandom_range(0, 2))
                0:       zs = 24'h000000;
                1:       zs = 24'($urandom());
                default: zs = 24'($urandom_range(0, 16'h3FFF));
            endcase
            n_items = (sel == 5 || sel == 6) ? BAD_PHASE_ITEMS : PHASE_ITEMS;
            set_grid(cx, cy, cz, zs);
            idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < n_items; k++)
            begin
                op = ($urandom_range(0, 99) == 0) ? OP_CLEAR : OP_INSERT;
                send_item(op, 16'($urandom()), pick_coord(grid_x, '0), pick_coord(grid_y, '0),
                          pick_coord(grid_z, slab_base), 1'b0, NO_RESULT);
            end
        end

        wait_drain();
        if (expected_bins.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_bins.size()));
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/plcl_pkg.sv
hdl/plcl_ram.sv
hdl/plcl_front.sv
hdl/plcl_queue.sv
hdl/plcl_back.sv
hdl/particle_cell_list_builder.sv
hdl/plcl_checker.sv
tb/sv/tb_top.sv
